/* hdl/utf8_validating_decoder_core_assert.svh */
// Assertion macros used by the UTF-8 validating decoder core.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8VD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8VD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/u8vd_pkg.sv */
// Shared types and constants of the UTF-8 validating decoder.
// Used by u8vd_step and utf8_validating_decoder_core; depends on nothing.
package u8vd_pkg;

  localparam int MAX_STRING_BYTES = 65536;
  localparam int COUNT_W = 17;
  localparam int CP_W = 21;
  localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] GLYPH_LIMIT =
    (MAX_STRING_BYTES < COUNT_FIELD_MAX) ? COUNT_W'(MAX_STRING_BYTES)
                                         : COUNT_W'(COUNT_FIELD_MAX);

  localparam logic [2:0] CLS_ANY     = 3'd0;
  localparam logic [2:0] CLS_A0_BF   = 3'd1;
  localparam logic [2:0] CLS_80_9F   = 3'd2;
  localparam logic [2:0] CLS_90_BF   = 3'd3;
  localparam logic [2:0] CLS_80_8F   = 3'd4;
  localparam logic [2:0] CLS_ONLY_80 = 3'd5;

  localparam logic [1:0] STATUS_CONT  = 2'd0;
  localparam logic [1:0] STATUS_VALID = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_FIRST = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_LAST  = 21'h00DFFF;

  typedef struct packed {
    logic [1:0]         rem;
    logic [2:0]         cls;
    logic               exp2;
    logic [CP_W-1:0]    accum;
    logic [COUNT_W-1:0] total;
    logic               err;
  } u8vd_state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic [CP_W-1:0]    cp;
    logic               done;
  } u8vd_result_t;

endpackage

/* hdl/u8vd_step.sv */
// Next-state and result logic for one byte of the UTF-8 validating decoder.
// Depends on u8vd_pkg.
module u8vd_step (
  input  u8vd_pkg::u8vd_state_t  st,
  input  logic [7:0]             byte_value,
  input  logic                   last_byte,
  input  logic                   allow_null,
  output u8vd_pkg::u8vd_state_t  st_nxt,
  output u8vd_pkg::u8vd_result_t res
);
  import u8vd_pkg::*;

  logic            sec_ok;
  logic            cont_ok;
  logic            done;
  logic [CP_W-1:0] cp_v;

  always_comb begin
    case (st.cls)
      CLS_A0_BF:   sec_ok = (byte_value >= 8'hA0) && (byte_value <= 8'hBF);
      CLS_80_9F:   sec_ok = (byte_value >= 8'h80) && (byte_value <= 8'h9F);
      CLS_90_BF:   sec_ok = (byte_value >= 8'h90) && (byte_value <= 8'hBF);
      CLS_80_8F:   sec_ok = (byte_value >= 8'h80) && (byte_value <= 8'h8F);
      CLS_ONLY_80: sec_ok = (byte_value == 8'h80);
      default:     sec_ok = (byte_value[7:6] == 2'b10);
    endcase
  end

  always_comb begin
    st_nxt  = st;
    done    = 1'b0;
    cp_v    = '0;
    cont_ok = st.exp2 ? sec_ok : (byte_value[7:6] == 2'b10);
    if (!st.err) begin
      if (st.rem == 2'd0) begin
        unique case (byte_value) inside
          [8'h00:8'h7F]: begin
            done = 1'b1;
            cp_v = {13'd0, byte_value};
          end
          8'hC0: begin
            if (allow_null) begin
              st_nxt.rem   = 2'd1;
              st_nxt.cls   = CLS_ONLY_80;
              st_nxt.exp2  = 1'b1;
              st_nxt.accum = '0;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          [8'hC2:8'hDF]: begin
            st_nxt.rem   = 2'd1;
            st_nxt.cls   = CLS_ANY;
            st_nxt.exp2  = 1'b1;
            st_nxt.accum = {16'd0, byte_value[4:0]};
          end
          [8'hE0:8'hEF]: begin
            st_nxt.rem   = 2'd2;
            st_nxt.cls   = (byte_value == 8'hE0) ? CLS_A0_BF :
                           (byte_value == 8'hED) ? CLS_80_9F : CLS_ANY;
            st_nxt.exp2  = 1'b1;
            st_nxt.accum = {17'd0, byte_value[3:0]};
          end
          [8'hF0:8'hF4]: begin
            st_nxt.rem   = 2'd3;
            st_nxt.cls   = (byte_value == 8'hF0) ? CLS_90_BF :
                           (byte_value == 8'hF4) ? CLS_80_8F : CLS_ANY;
            st_nxt.exp2  = 1'b1;
            st_nxt.accum = {18'd0, byte_value[2:0]};
          end
          default: begin
            st_nxt.err = 1'b1;
          end
        endcase
      end else if (!cont_ok) begin
        st_nxt.err   = 1'b1;
        st_nxt.rem   = 2'd0;
        st_nxt.exp2  = 1'b0;
        st_nxt.cls   = CLS_ANY;
        st_nxt.accum = '0;
      end else begin
        st_nxt.exp2  = 1'b0;
        st_nxt.cls   = CLS_ANY;
        st_nxt.accum = {st.accum[CP_W-7:0], byte_value[5:0]};
        st_nxt.rem   = st.rem - 2'd1;
        if (st.rem == 2'd1) begin
          done = 1'b1;
          cp_v = {st.accum[CP_W-7:0], byte_value[5:0]};
        end
      end
    end

    if (done) begin
      st_nxt.accum = '0;
      if (st.total < GLYPH_LIMIT) begin
        st_nxt.total = st.total + 1'b1;
      end
    end

    res.done   = done;
    res.cp     = cp_v;
    res.count  = st_nxt.total;
    res.status = STATUS_CONT;

    if (last_byte) begin
      if (!st_nxt.err && (st_nxt.rem != 2'd0)) begin
        st_nxt.err = 1'b1;
      end
      res.status = st_nxt.err ? STATUS_ERROR : STATUS_VALID;
      st_nxt     = '0;
    end
  end

endmodule

/* hdl/utf8_validating_decoder_core.sv */
// An accepted byte is held in an input register, and its result is registered in out_r.
// Throughput: one byte per cycle unless out_tready stalls the output; u8vd_step is combinational.
// Reset (synchronous, rst_n low) clears both pipeline valid flags, the string state,
// and sets allow_modified_null to 1.
// Top level of the UTF-8 validating decoder; depends on u8vd_pkg, u8vd_step and the assert header.
module utf8_validating_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // allow_modified_null
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] byte_value
  input  logic        in_tlast,      // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // [20:0] code_point, [37:21] glyph_count, [39:38] status
  output logic        out_tuser      // glyph_done
);
  import u8vd_pkg::*;

  `include "utf8_validating_decoder_core_assert.svh"

  logic         allow_null_r;
  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         out_vld_r;
  u8vd_result_t out_r;
  u8vd_result_t res;
  u8vd_state_t  st_r;
  u8vd_state_t  st_nxt;
  logic         advance;
  logic         fire;

  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  u8vd_step u_step (
    .st         (st_r),
    .byte_value (in_byte_r),
    .last_byte  (in_last_r),
    .allow_null (allow_null_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_null_r <= 1'b1;
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      st_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        allow_null_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.status, out_r.count, out_r.cp};
  assign out_tuser  = out_r.done;

  `U8VD_ASSERT_SAME(a_cp_is_scalar,
    out_vld_r && out_r.done,
    (out_r.cp <= CP_MAX) && !((out_r.cp >= CP_SURR_FIRST) && (out_r.cp <= CP_SURR_LAST)),
    "decoded code point is not a Unicode scalar value")
  `U8VD_ASSERT_SAME(a_cp_zero_idle,
    out_vld_r && !out_r.done,
    out_r.cp == '0,
    "code point is nonzero without a completed glyph")
  `U8VD_ASSERT_NEXT(a_clear_after_last,
    fire && in_last_r,
    (st_r.rem == 2'd0) && (st_r.total == '0) && !st_r.err && (out_r.status != STATUS_CONT),
    "string state not cleared or status missing after the last item")
  `U8VD_ASSERT_NEXT(a_no_glyph_after_error,
    fire && st_r.err,
    !out_r.done && (out_r.count == $past(st_r.total)),
    "glyph reported after the string error latched")
  `U8VD_ASSERT_NEXT(a_status_only_at_last,
    fire && !in_last_r,
    out_r.status == STATUS_CONT,
    "final status given on an item that is not the last")

endmodule
